/* rtl/core/matrix3_inverse_macros.svh */
// Assertion macros used by the core RTL top level (matrix3_inverse).
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MI3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mi3_pkg.sv */
`timescale 1ns / 1ps
package mi3_pkg;

    localparam int IN_W      = 16;
    localparam int IN_FRAC   = 12;
    localparam int OUT_FRAC  = 16;
    localparam int OUT_W     = 32;
    localparam int DIV_BITS  = OUT_W;
    localparam int CROSS_W   = 2 * IN_W + 1;
    localparam int DT_W      = CROSS_W + IN_W;
    localparam int DET_W     = DT_W + 2;
    localparam int NUM_SH    = IN_FRAC + OUT_FRAC + 1;
    localparam int NUM_W     = CROSS_W + NUM_SH + 1;
    localparam int DEN_W     = DET_W + 1;
    localparam int CMP_W     = DEN_W + DIV_BITS;
    localparam int FRONT_STG = 3;
    localparam int LAT       = FRONT_STG + 1 + DIV_BITS + 1;
    localparam int LANES     = 9;

    typedef struct packed {
        logic signed [IN_W-1:0] a00;
        logic signed [IN_W-1:0] a01;
        logic signed [IN_W-1:0] a02;
        logic signed [IN_W-1:0] a10;
        logic signed [IN_W-1:0] a11;
        logic signed [IN_W-1:0] a12;
        logic signed [IN_W-1:0] a20;
        logic signed [IN_W-1:0] a21;
        logic signed [IN_W-1:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] b00;
        logic signed [OUT_W-1:0] b01;
        logic signed [OUT_W-1:0] b02;
        logic signed [OUT_W-1:0] b10;
        logic signed [OUT_W-1:0] b11;
        logic signed [OUT_W-1:0] b12;
        logic signed [OUT_W-1:0] b20;
        logic signed [OUT_W-1:0] b21;
        logic signed [OUT_W-1:0] b22;
        logic                    singular;
        logic                    saturated;
    } inv_t;

    // Front end result: adjugate rows plus determinant magnitude and sign
    typedef struct packed {
        logic [LANES-1:0][CROSS_W-1:0] cr;
        logic [DET_W-1:0]              dmag;
        logic                          dneg;
        logic                          dzero;
    } front_t;

    // One lane's quotient with its sign and range flags
    typedef struct packed {
        logic [DIV_BITS-1:0] q;
        logic                neg;
        logic                ovf;
        logic                zero;
    } lane_t;

endpackage

/* rtl/core/mi3_front.sv */
`timescale 1ns / 1ps
module mi3_front
    import mi3_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  mat_t   mat,
    output front_t front
);

    function automatic int nx(input int i, input int k);
        nx = (i + k > 2) ? i + k - 3 : i + k;
    endfunction

    logic signed [IN_W-1:0]    el [3][3];
    logic signed [CROSS_W-1:0] cr_next [LANES];
    logic signed [CROSS_W-1:0] cr_reg [LANES];
    logic signed [IN_W-1:0]    c2_reg [3];
    logic signed [CROSS_W-1:0] crb_reg [LANES];
    logic signed [DT_W-1:0]    dt_reg [3];
    logic signed [DET_W-1:0]   det;
    logic signed [CROSS_W-1:0] crc_reg [LANES];
    logic [DET_W-1:0]          dmag_reg;
    logic                      dneg_reg;
    logic                      dzero_reg;

    assign el[0][0] = mat.a00;
    assign el[0][1] = mat.a01;
    assign el[0][2] = mat.a02;
    assign el[1][0] = mat.a10;
    assign el[1][1] = mat.a11;
    assign el[1][2] = mat.a12;
    assign el[2][0] = mat.a20;
    assign el[2][1] = mat.a21;
    assign el[2][2] = mat.a22;

    // Row i of the adjugate is col(i+1) x col(i+2); el[r][c] is row r, column c
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cr_next[i*3+j] =
                    CROSS_W'(el[nx(j, 1)][nx(i, 1)]) * CROSS_W'(el[nx(j, 2)][nx(i, 2)])
                  - CROSS_W'(el[nx(j, 2)][nx(i, 1)]) * CROSS_W'(el[nx(j, 1)][nx(i, 2)]);
            end
        end
    end

    assign det = DET_W'(dt_reg[0]) + DET_W'(dt_reg[1]) + DET_W'(dt_reg[2]);

    // Three stages: cross products, determinant terms, determinant sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                cr_reg[k]  <= cr_next[k];
                crb_reg[k] <= cr_reg[k];
                crc_reg[k] <= crb_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                c2_reg[j] <= el[j][2];
                dt_reg[j] <= DT_W'(cr_reg[6+j]) * DT_W'(c2_reg[j]);
            end
            dneg_reg  <= det[DET_W-1];
            dzero_reg <= (det == '0);
            dmag_reg  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            front.cr[k] = crc_reg[k];
        end
        front.dmag  = dmag_reg;
        front.dneg  = dneg_reg;
        front.dzero = dzero_reg;
    end

endmodule

/* rtl/core/mi3_div_lane.sv */
`timescale 1ns / 1ps
module mi3_div_lane
    import mi3_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [CROSS_W-1:0] cr,
    input  logic [DET_W-1:0]   dmag,
    input  logic               dneg,
    input  logic               dzero,
    output lane_t              lane
);

    logic [NUM_W-1:0]    rem_reg  [DIV_BITS+1];
    logic [DIV_BITS-1:0] q_reg    [DIV_BITS+1];
    logic [DEN_W-1:0]    den_reg  [DIV_BITS+1];
    logic                neg_reg  [DIV_BITS+1];
    logic                ovf_reg  [DIV_BITS+1];
    logic                zero_reg [DIV_BITS+1];

    logic [CROSS_W-1:0] mag;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;

    // Rounded quotient: (|c| * 2^(NUM_SH) + |D|) / (2|D|)
    assign mag = cr[CROSS_W-1] ? CROSS_W'(-cr) : cr;
    assign num = (NUM_W'(mag) << NUM_SH) + NUM_W'(dmag);
    assign den = {dmag, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            neg_reg[0]  <= cr[CROSS_W-1] ^ dneg;
            ovf_reg[0]  <= CMP_W'(num) >= (CMP_W'(den) << DIV_BITS);
            zero_reg[0] <= dzero;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 0; s < DIV_BITS; s++)
    begin : g_stage
        localparam int K = DIV_BITS - 1 - s;
        logic [CMP_W-1:0] dsh;
        logic             take;

        assign dsh  = CMP_W'(den_reg[s]) << K;
        assign take = CMP_W'(rem_reg[s]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= take ? NUM_W'(CMP_W'(rem_reg[s]) - dsh) : rem_reg[s];
                q_reg[s+1]    <= q_reg[s] | (take ? (DIV_BITS'(1) << K) : '0);
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    assign lane.q    = q_reg[DIV_BITS];
    assign lane.neg  = neg_reg[DIV_BITS];
    assign lane.ovf  = ovf_reg[DIV_BITS];
    assign lane.zero = zero_reg[DIV_BITS];

endmodule

/* rtl/core/mi3_merge.sv */
`timescale 1ns / 1ps
module mi3_merge
    import mi3_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  lane_t lane [LANES],
    output inv_t  inv
);

    logic [OUT_W-1:0] val [LANES];
    logic [LANES-1:0] sat;
    inv_t             inv_next;
    inv_t             inv_reg;

    // Clip each lane to the signed output range and apply the sign
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            logic [DIV_BITS-1:0] lim;
            logic [DIV_BITS-1:0] m;
            lim    = lane[k].neg ? (DIV_BITS'(1) << (OUT_W - 1))
                                 : ((DIV_BITS'(1) << (OUT_W - 1)) - DIV_BITS'(1));
            sat[k] = !lane[k].zero && (lane[k].ovf || lane[k].q > lim);
            m      = sat[k] ? lim : lane[k].q;
            if (lane[k].zero)
                val[k] = '0;
            else
                val[k] = lane[k].neg ? OUT_W'(-m) : OUT_W'(m);
        end
    end

    always_comb
    begin
        inv_next.b00       = val[0];
        inv_next.b01       = val[1];
        inv_next.b02       = val[2];
        inv_next.b10       = val[3];
        inv_next.b11       = val[4];
        inv_next.b12       = val[5];
        inv_next.b20       = val[6];
        inv_next.b21       = val[7];
        inv_next.b22       = val[8];
        inv_next.singular  = lane[0].zero;
        inv_next.saturated = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= inv_next;
        end
    end

    assign inv = inv_reg;

endmodule

/* rtl/core/matrix3_inverse.sv */
`timescale 1ns / 1ps
// 3x3 matrix inverse through the adjugate: one matrix beat in and one inverse beat out per
// clock, through three front-end stages for the cross products and determinant,
// one setup stage and 32 restoring-division stages in each of nine parallel element lanes,
// and one merge/output register. The whole pipeline holds while a result waits to be
// taken, so mat_ready follows inv_ready. Inputs are signed Q4.12, outputs signed Q16.16,
// rounded to nearest with ties away from zero and clipped; a zero determinant gives all
// zero elements with singular set.
`include "matrix3_inverse_macros.svh"
module matrix3_inverse
    import mi3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    output logic mat_ready,
    input  mat_t mat,
    output logic inv_valid,
    input  logic inv_ready,
    output inv_t inv
);

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;
    front_t         front;
    lane_t          lane [LANES];

    // Pipeline advances unless the output beat is stalled
    assign en        = !vld_reg[LAT-1] || inv_ready;
    assign mat_ready = en;
    assign inv_valid = vld_reg[LAT-1];
    assign vld_next  = en ? {vld_reg[LAT-2:0], mat_valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    mi3_front u_front
    (
        .clk   (clk),
        .en    (en),
        .mat   (mat),
        .front (front)
    );

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        mi3_div_lane u_lane
        (
            .clk   (clk),
            .en    (en),
            .cr    (front.cr[k]),
            .dmag  (front.dmag),
            .dneg  (front.dneg),
            .dzero (front.dzero),
            .lane  (lane[k])
        );
    end

    mi3_merge u_merge
    (
        .clk  (clk),
        .en   (en),
        .lane (lane),
        .inv  (inv)
    );

    `MI3_ASSERT_IMP(a_sing_zero, inv_valid && inv.singular, !inv.saturated && inv.b00 == '0 && inv.b11 == '0 && inv.b22 == '0, "singular beat with nonzero data")
    `MI3_ASSERT_NXT(a_accept_enters, mat_valid && mat_ready, vld_reg[0], "accepted beat did not enter pipeline")
    `MI3_ASSERT_NXT(a_stall_holds, !en, $stable(vld_reg), "pipeline moved while stalled")

endmodule
